// ----- sv/assert_macros.svh -----
// shared assertion macros for the k-mer counter checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is held
`define KMR_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked assertion that is also checked at the first edge after reset
`define KMR_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/kmr_pkg.sv -----
package kmr_pkg;

	localparam int MAX_KMER_LENGTH = 8;
	localparam int COUNT_WIDTH     = 20;
	localparam int IDX_W           = 2 * MAX_KMER_LENGTH;
	localparam int TABLE_DEPTH     = 1 << IDX_W;
	localparam int FILL_W          = $clog2(MAX_KMER_LENGTH + 1);
	localparam int KLEN_W          = 4;
	localparam int CMD_W           = 2;
	localparam int BASE_W          = 2;
	localparam int QIDX_W          = 16;
	localparam int OUT_IDX_W       = 16;
	localparam int FIFO_DEPTH      = 4;
	localparam int FIFO_AW         = $clog2(FIFO_DEPTH);

	localparam logic [KLEN_W-1:0]      KLEN_RESET = KLEN_W'(4);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = '1;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH    = 2'd0,
		CMD_READ    = 2'd1,
		CMD_NEW_SEQ = 2'd2,
		CMD_IGNORE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_COUNT = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] idx;
	} kmr_entry_t;

	// k of zero acts as one, above the maximum acts as the maximum
	function automatic logic [KLEN_W-1:0] eff_k(input logic [KLEN_W-1:0] k);
		logic [KLEN_W-1:0] r;
		r = k;
		if (k == '0)
			r = KLEN_W'(1);
		else if (k > KLEN_W'(MAX_KMER_LENGTH))
			r = KLEN_W'(MAX_KMER_LENGTH);
		return r;
	endfunction

	function automatic logic [IDX_W-1:0] digit_mask(input logic [KLEN_W-1:0] k);
		logic [IDX_W-1:0] m;
		m = '0;
		for (int i = 0; i < MAX_KMER_LENGTH; i++) begin
			if (KLEN_W'(i) < k)
				m[2*i +: 2] = 2'b11;
		end
		return m;
	endfunction

endpackage

// ----- sv/kmr_front.sv -----
module kmr_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [kmr_pkg::CMD_W-1:0]     command,
	input  logic [kmr_pkg::BASE_W-1:0]    base_code,
	input  logic [kmr_pkg::QIDX_W-1:0]    query_index,
	input  logic                          cfg_valid,
	input  logic [kmr_pkg::KLEN_W-1:0]    cfg_data,
	input  logic                          fifo_full,
	input  logic                          clearing,
	output logic                          push,
	output kmr_pkg::kmr_entry_t           push_entry
);
	import kmr_pkg::*;

	logic [KLEN_W-1:0] klen_q;
	logic [IDX_W-1:0]  window_q;
	logic [FILL_W-1:0] filled_q;

	logic [KLEN_W-1:0] k_eff;
	logic [IDX_W-1:0]  window_nx;
	logic [FILL_W-1:0] filled_nx;

	assign in_stall = fifo_full | clearing;
	assign push     = in_valid & ~in_stall;

	assign k_eff     = eff_k(klen_q);
	assign window_nx = IDX_W'({window_q, base_code});
	assign filled_nx = (filled_q < FILL_W'(MAX_KMER_LENGTH)) ? filled_q + FILL_W'(1) : filled_q;

	always_comb begin
		push_entry.op  = OP_NONE;
		push_entry.idx = '0;
		case (command)
			CMD_PUSH: begin
				push_entry.idx = window_nx & digit_mask(k_eff);
				if (filled_nx >= FILL_W'(k_eff))
					push_entry.op = OP_COUNT;
			end
			CMD_READ: begin
				push_entry.op  = OP_READ;
				push_entry.idx = IDX_W'(query_index);
			end
			default: begin
				push_entry.op  = OP_NONE;
				push_entry.idx = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q   <= KLEN_RESET;
			window_q <= '0;
			filled_q <= '0;
		end else begin
			if (cfg_valid)
				klen_q <= cfg_data;
			if (push) begin
				case (command)
					CMD_PUSH: begin
						window_q <= window_nx;
						filled_q <= filled_nx;
					end
					CMD_NEW_SEQ: begin
						window_q <= '0;
						filled_q <= '0;
					end
					default: begin
						window_q <= window_q;
					end
				endcase
			end
		end
	end

endmodule

// ----- sv/kmr_fifo.sv -----
module kmr_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  kmr_pkg::kmr_entry_t push_entry,
	input  logic                pop,
	output kmr_pkg::kmr_entry_t head,
	output logic                empty,
	output logic                full
);
	import kmr_pkg::*;

	kmr_entry_t         slot_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			if (push && !pop)
				count_q <= count_q + (FIFO_AW+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (FIFO_AW+1)'(1);
		end
	end

endmodule

// ----- sv/kmr_back.sv -----
module kmr_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             fifo_empty,
	input  kmr_pkg::kmr_entry_t              fifo_head,
	output logic                             pop,
	output logic                             clearing,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             kmer_counted,
	output logic [kmr_pkg::OUT_IDX_W-1:0]    kmer_index,
	output logic [kmr_pkg::COUNT_WIDTH-1:0]  count_value
);
	import kmr_pkg::*;

	logic [COUNT_WIDTH-1:0] count_mem [TABLE_DEPTH];

	logic                   clear_q;
	logic [IDX_W-1:0]       clr_addr_q;

	logic                   valid_s1;
	kmr_entry_t             entry_s1;
	logic [COUNT_WIDTH-1:0] rdata_s1;

	logic                   fwd_hit_q;
	logic [COUNT_WIDTH-1:0] fwd_data_q;

	logic                   out_valid_s2;
	logic                   counted_s2;
	logic [OUT_IDX_W-1:0]   index_s2;
	logic [COUNT_WIDTH-1:0] count_s2;

	logic                   adv;
	logic                   wr_en;
	logic [COUNT_WIDTH-1:0] cnt_cur;
	logic [COUNT_WIDTH-1:0] cnt_new;

	assign clearing = clear_q;
	assign adv      = ~out_valid_s2 | ~out_stall;
	assign pop      = adv & ~fifo_empty & ~clear_q;
	assign wr_en    = adv & valid_s1 & (entry_s1.op == OP_COUNT);

	// the previous word's write lands on the same edge as this word's read
	assign cnt_cur = fwd_hit_q ? fwd_data_q : rdata_s1;
	assign cnt_new = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + COUNT_WIDTH'(1);

	always_ff @(posedge clk) begin
		if (clear_q)
			count_mem[clr_addr_q] <= '0;
		else if (wr_en)
			count_mem[entry_s1.idx] <= cnt_new;
		if (pop)
			rdata_s1 <= count_mem[fifo_head.idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q      <= 1'b1;
			clr_addr_q   <= '0;
			valid_s1     <= 1'b0;
			fwd_hit_q    <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (clear_q) begin
				clr_addr_q <= clr_addr_q + IDX_W'(1);
				if (&clr_addr_q)
					clear_q <= 1'b0;
			end
			if (adv) begin
				valid_s1     <= pop;
				fwd_hit_q    <= pop & wr_en & (fifo_head.idx == entry_s1.idx);
				out_valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			entry_s1 <= fifo_head;
		if (adv)
			fwd_data_q <= cnt_new;
		if (adv && valid_s1) begin
			index_s2 <= OUT_IDX_W'(entry_s1.idx);
			case (entry_s1.op)
				OP_COUNT: begin
					counted_s2 <= 1'b1;
					count_s2   <= cnt_new;
				end
				OP_READ: begin
					counted_s2 <= 1'b0;
					count_s2   <= cnt_cur;
				end
				default: begin
					counted_s2 <= 1'b0;
					count_s2   <= '0;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_s2;
	assign kmer_counted = counted_s2;
	assign kmer_index   = index_s2;
	assign count_value  = count_s2;

endmodule

// ----- sv/kmer_rolling_counter.sv -----
// path: a taken word passes the FIFO, the s1 table read and the s2 output register
// throughput: one word per cycle when not stalled; the counter table is read and written
//   once a cycle, back-to-back updates of one index go through a forwarding register
// reset: arst_n clears control state at once, then a clearing pass zeroes all 65536
//   counter table entries while in_stall stays high; config writes are still taken
module kmer_rolling_counter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [kmr_pkg::CMD_W-1:0]        command,
	input  logic [kmr_pkg::BASE_W-1:0]       base_code,
	input  logic [kmr_pkg::QIDX_W-1:0]       query_index,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             kmer_counted,
	output logic [kmr_pkg::OUT_IDX_W-1:0]    kmer_index,
	output logic [kmr_pkg::COUNT_WIDTH-1:0]  count_value,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [kmr_pkg::KLEN_W-1:0]       cfg_data
);
	import kmr_pkg::*;

	logic       push;
	kmr_entry_t push_entry;
	logic       pop;
	kmr_entry_t head;
	logic       empty;
	logic       full;
	logic       clearing;

	assign cfg_ready = 1'b1;

	kmr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.base_code   (base_code),
		.query_index (query_index),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.fifo_full   (full),
		.clearing    (clearing),
		.push        (push),
		.push_entry  (push_entry)
	);

	kmr_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.empty      (empty),
		.full       (full)
	);

	kmr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.fifo_empty   (empty),
		.fifo_head    (head),
		.pop          (pop),
		.clearing     (clearing),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kmer_counted (kmer_counted),
		.kmer_index   (kmer_index),
		.count_value  (count_value)
	);

endmodule

// ----- sv/kmr_checker.sv -----
`include "assert_macros.svh"

module kmr_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic                             kmer_counted,
	input logic [kmr_pkg::OUT_IDX_W-1:0]    kmer_index,
	input logic [kmr_pkg::COUNT_WIDTH-1:0]  count_value
);
	import kmr_pkg::*;

	// a stalled result word holds
	`KMR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(kmer_index) && $stable(count_value) && $stable(kmer_counted), "result changed while stalled")

	// a counted k-mer never reports a zero count
	`KMR_ASSERT(a_counted_nonzero, out_valid && kmer_counted |-> count_value != '0, "counted k-mer with zero count")

	// table clear holds off input straight after reset
	`KMR_ASSERT_ALWAYS(a_clear_stall, $rose(arst_n) |-> in_stall && !out_valid, "input open before table clear")

	// nothing comes out without a word having gone in first
	`KMR_ASSERT(a_no_phantom, $past(in_stall) && $past(in_stall, 2) && $past(in_stall, 3) && !$past(out_valid) |-> !out_valid, "result with no word taken")

endmodule

bind kmer_rolling_counter kmr_checker u_kmr_checker (.*);

// ----- verif/tb_kmer_rolling_counter.sv -----
`timescale 1ns / 1ps

module tb_kmer_rolling_counter;

	import kmr_pkg::*;

	localparam int IDLE_LIMIT = 400000;
	localparam int WORD_BACKLOG = 16;

	typedef struct {
		cmd_t                  command;
		logic [BASE_W-1:0]     base;
		logic [QIDX_W-1:0]     query;
	} kmer_word_t;

	typedef struct {
		logic                  counted;
		logic [OUT_IDX_W-1:0]  index;
		logic [COUNT_WIDTH-1:0] count;
	} kmer_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	cmd_t command = CMD_PUSH;
	logic [BASE_W-1:0] base_code = '0;
	logic [QIDX_W-1:0] query_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic kmer_counted;
	logic [OUT_IDX_W-1:0] kmer_index;
	logic [COUNT_WIDTH-1:0] count_value;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [KLEN_W-1:0] cfg_data = '0;

	// predictor state
	logic [KLEN_W-1:0] klen_reg = KLEN_RESET;
	logic [IDX_W-1:0] kmer_window = '0;
	int unsigned bases_seen = 0;
	bit [COUNT_WIDTH-1:0] kmer_counts [TABLE_DEPTH];

	kmer_word_t base_words [$];
	kmer_report_t kmer_reports [$];

	int gap_max = 7;
	int gap_left = 0;
	int stall_left = 0;
	int idle_cycles = 0;
	int unsigned queued_words = 0;
	int unsigned accepted_words = 0;
	int unsigned checked_reports = 0;
	int unsigned counted_pushes = 0;
	int unsigned saturated_hits = 0;
	int unsigned klen_writes = 0;
	int unsigned err_count = 0;
	int kmer_plan [10] = '{0, 1, 8, 15, 2, 9, 3, 5, 6, 7};

	kmer_rolling_counter DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.base_code    (base_code),
		.query_index  (query_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kmer_counted (kmer_counted),
		.kmer_index   (kmer_index),
		.count_value  (count_value),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	// rolling window update and table count for one accepted word
	function automatic void tally_kmer(input kmer_word_t w);
		kmer_report_t r;
		int unsigned k;
		logic [IDX_W-1:0] idx_mask;
		r.counted = 1'b0;
		r.index = '0;
		r.count = '0;
		if (klen_reg == 0)
			k = 1;
		else if (klen_reg > MAX_KMER_LENGTH)
			k = MAX_KMER_LENGTH;
		else
			k = klen_reg;
		idx_mask = IDX_W'((32'd1 << (2 * k)) - 1);
		case (w.command)
			CMD_PUSH: begin
				kmer_window = {kmer_window[IDX_W-3:0], w.base};
				if (bases_seen < MAX_KMER_LENGTH)
					bases_seen++;
				r.index = OUT_IDX_W'(kmer_window & idx_mask);
				if (bases_seen >= k) begin
					if (kmer_counts[r.index] != COUNT_MAX)
						kmer_counts[r.index]++;
					else
						saturated_hits++;
					r.counted = 1'b1;
					r.count = kmer_counts[r.index];
					counted_pushes++;
				end
			end
			CMD_READ: begin
				r.index = w.query;
				r.count = kmer_counts[w.query];
			end
			CMD_NEW_SEQ: begin
				kmer_window = '0;
				bases_seen = 0;
			end
			default: ;
		endcase
		kmer_reports.push_back(r);
	endfunction

	// driver: one word at a time, random gap after each
	always @(posedge clk or negedge arst_n) begin
		kmer_word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				w.command = command;
				w.base = base_code;
				w.query = query_index;
				tally_kmer(w);
				accepted_words++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (base_words.size() != 0) begin
					w = base_words.pop_front();
					command <= w.command;
					base_code <= w.base;
					query_index <= w.query;
					in_valid <= 1'b1;
					gap_left <= $urandom_range(0, gap_max);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each taken result with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		kmer_report_t exp_r;
		int hold;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			hold = stall_left;
			if (out_valid && !out_stall) begin
				hold = $urandom_range(0, gap_max);
				if (kmer_reports.size() == 0) begin
					$error("result with no prediction waiting: index %0h count %0d",
						kmer_index, count_value);
					err_count++;
				end else begin
					exp_r = kmer_reports.pop_front();
					checked_reports++;
					if (kmer_counted !== exp_r.counted) begin
						$error("kmer_counted: expected %0d, got %0d", exp_r.counted, kmer_counted);
						err_count++;
					end
					if (kmer_index !== exp_r.index) begin
						$error("kmer_index: expected %0h, got %0h", exp_r.index, kmer_index);
						err_count++;
					end
					if (count_value !== exp_r.count) begin
						$error("count_value: expected %0d, got %0d", exp_r.count, count_value);
						err_count++;
					end
				end
			end
			if (hold != 0) begin
				out_stall <= 1'b1;
				stall_left <= hold - 1;
			end else begin
				out_stall <= 1'b0;
				stall_left <= 0;
			end
		end
	end

	// watchdog on cycles with no word moving on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: %0d cycles without progress", IDLE_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic queue_word(input cmd_t c, input logic [BASE_W-1:0] b,
			input logic [QIDX_W-1:0] q);
		kmer_word_t w;
		while (base_words.size() >= WORD_BACKLOG)
			@(posedge clk);
		w.command = c;
		w.base = b;
		w.query = q;
		base_words.push_back(w);
		queued_words++;
	endtask

	task automatic drain_words();
		while (accepted_words != queued_words || kmer_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_kmer_length(input logic [KLEN_W-1:0] v);
		@(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		klen_reg = v;
		klen_writes++;
	endtask

	// mostly pushes, often of a short repeating motif so that k-mers recur
	task automatic random_words(input int n, input int k);
		int r;
		int unsigned span;
		logic [BASE_W-1:0] motif [3];
		logic [BASE_W-1:0] b;
		logic [QIDX_W-1:0] q;
		span = 1 << (2 * k);
		foreach (motif[j])
			motif[j] = BASE_W'($urandom);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			b = BASE_W'($urandom);
			q = QIDX_W'($urandom);
			if (r < 78) begin
				if (r < 40)
					b = motif[i % 3];
				queue_word(CMD_PUSH, b, q);
			end else if (r < 90) begin
				if (r < 85)
					q = QIDX_W'($urandom_range(0, span - 1));
				queue_word(CMD_READ, b, q);
			end else if (r < 97) begin
				queue_word(CMD_NEW_SEQ, b, q);
			end else begin
				queue_word(CMD_IGNORE, b, q);
			end
		end
	endtask

	initial begin
		int k_eff;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed part at the reset value of k
		queue_word(CMD_READ, 2'd0, 16'h0000);
		queue_word(CMD_READ, 2'd3, 16'hFFFF);
		queue_word(CMD_IGNORE, 2'd3, 16'hFFFF);
		repeat (5) queue_word(CMD_PUSH, 2'd3, 16'hFFFF);
		queue_word(CMD_READ, 2'd0, 16'h00FF);
		queue_word(CMD_NEW_SEQ, 2'd3, 16'hFFFF);
		queue_word(CMD_PUSH, 2'd0, 16'h0000);
		queue_word(CMD_PUSH, 2'd1, 16'h0000);
		queue_word(CMD_PUSH, 2'd2, 16'h0000);
		queue_word(CMD_PUSH, 2'd3, 16'h0000);
		queue_word(CMD_PUSH, 2'd0, 16'h5555);
		queue_word(CMD_READ, 2'd1, 16'h001B);
		queue_word(CMD_NEW_SEQ, 2'd0, 16'h0000);
		queue_word(CMD_PUSH, 2'd2, 16'hAAAA);
		queue_word(CMD_READ, 2'd2, 16'h0002);
		queue_word(CMD_IGNORE, 2'd0, 16'h0000);
		drain_words();

		// k changes between phases without a new sequence, so the window carries over
		kmer_plan[9] = $urandom_range(0, 15);
		foreach (kmer_plan[p]) begin
			set_kmer_length(KLEN_W'(kmer_plan[p]));
			gap_max = (p % 3 == 2) ? 0 : 7;
			k_eff = (kmer_plan[p] == 0) ? 1 :
				(kmer_plan[p] > MAX_KMER_LENGTH ? MAX_KMER_LENGTH : kmer_plan[p]);
			random_words(200, k_eff);
			drain_words();
		end
		repeat (8) @(posedge clk);

		if (kmer_reports.size() != 0) begin
			$error("%0d predicted results never arrived", kmer_reports.size());
			err_count++;
		end
		$display("run: %0d words in, %0d results checked, %0d writes of kmer_length",
			accepted_words, checked_reports, klen_writes);
		$display("run: %0d k-mers counted, %0d pushes onto a saturated counter",
			counted_pushes, saturated_hits);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- kmer_rolling_counter.f -----
+incdir+sv
sv/kmr_pkg.sv
sv/kmr_front.sv
sv/kmr_fifo.sv
sv/kmr_back.sv
sv/kmer_rolling_counter.sv
sv/kmr_checker.sv
verif/tb_kmer_rolling_counter.sv
